>>> rtl/tmcc_pkg.sv
// tmcc_pkg: beat types, command codes and constants for the timed motor command controller
// no dependencies; used by every module of the block

package tmcc_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] rx_byte;
        logic       menu_button;
        logic       adjust_button;
    } t_in_item;

    typedef struct packed {
        logic       main_right_on;
        logic       main_left_on;
        logic [2:0] secondary_enables;
        logic [9:0] duty_word;
        logic [2:0] menu_mode;
        logic       accepting;
    } t_out_item;

    // operation codes
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // serial command bytes
    localparam logic [7:0] CMD_CIRCLE = 8'h43;
    localparam logic [7:0] CMD_RIGHT  = 8'h52;
    localparam logic [7:0] CMD_LEFT   = 8'h4C;
    localparam logic [7:0] CMD_STOP   = 8'h54;

    // settings slots
    localparam int SET_MAIN_DUTY = 0;
    localparam int SET_MAIN_TIME = 1;
    localparam int SET_SEC_DUTY  = 2;
    localparam int SET_SEC_TIME  = 3;
    localparam int NUM_SETTINGS  = 4;

    localparam logic [7:0] SET_RESET [NUM_SETTINGS] = '{8'h78, 8'd14, 8'h78, 8'd50};

    localparam logic [6:0] IDLE_LIMIT = 7'd100;
    localparam logic [6:0] IDLE_SAT   = 7'd101;
    localparam logic [7:0] DUTY_MAX   = 8'd100;
    localparam logic [9:0] DUTY_RESET = 10'd500;

    localparam logic [2:0] MODE_RUN  = 3'd0;
    localparam logic [2:0] MODE_LAST = 3'd4;

    localparam logic [1:0] SEL_FIRST = 2'd1;
    localparam logic [1:0] SEL_LAST  = 2'd3;

    // setting times ten, kept to 10 bits
    function automatic logic [9:0] duty_of(input logic [7:0] setting);
        logic [11:0] prod;
        prod = {1'b0, setting, 3'b000} + {3'b000, setting, 1'b0};
        return prod[9:0];
    endfunction

endpackage

>>> rtl/tmcc_in_reg.sv
// tmcc_in_reg: input register for command and tick beats
// depends on tmcc_pkg for the input beat type

module tmcc_in_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  tmcc_pkg::t_in_item i_in_data,
    input  logic              i_advance,
    output logic              o_in_stall,
    output logic              o_item_valid,
    output tmcc_pkg::t_in_item o_item
);

    logic               r_valid;
    tmcc_pkg::t_in_item r_item;

    // slot frees up when it is empty or its beat moves on this cycle
    assign o_in_stall = r_valid && !i_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall && i_in_valid) begin
            r_item <= i_in_data;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

>>> rtl/tmcc_core.sv
// tmcc_core: controller state and its single-pass update for one beat
// depends on tmcc_pkg for beat types, command codes and the duty function

module tmcc_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  tmcc_pkg::t_in_item  i_item,
    output tmcc_pkg::t_out_item o_result
);

    logic [1:0]  r_sel,  n_sel;
    logic [7:0]  r_run_len, n_run_len;
    logic [15:0] r_run_ticks, n_run_ticks;
    logic        r_running, n_running;
    logic [2:0]  r_mode, n_mode;
    logic [6:0]  r_idle, n_idle;
    logic [7:0]  r_work  [tmcc_pkg::NUM_SETTINGS];
    logic [7:0]  n_work  [tmcc_pkg::NUM_SETTINGS];
    logic [7:0]  r_saved [tmcc_pkg::NUM_SETTINGS];
    logic [7:0]  n_saved [tmcc_pkg::NUM_SETTINGS];
    logic [4:0]  r_lines, n_lines;
    logic [9:0]  r_duty, n_duty;

    logic [2:0]  sec_onehot;
    logic [7:0]  step_val;

    always_comb begin
        case (r_sel)
            2'd1:    sec_onehot = 3'b001;
            2'd2:    sec_onehot = 3'b010;
            2'd3:    sec_onehot = 3'b100;
            default: sec_onehot = 3'b000;
        endcase
    end

    always_comb begin
        n_sel       = r_sel;
        n_run_len   = r_run_len;
        n_run_ticks = r_run_ticks;
        n_running   = r_running;
        n_mode      = r_mode;
        n_idle      = r_idle;
        n_work      = r_work;
        n_saved     = r_saved;
        n_lines     = r_lines;
        n_duty      = r_duty;
        step_val    = 8'd0;

        if (i_item.operation == tmcc_pkg::OP_BYTE) begin
            if (!r_running) begin
                case (i_item.rx_byte)
                    tmcc_pkg::CMD_CIRCLE: begin
                        n_lines     = {sec_onehot, 2'b00};
                        n_duty      = tmcc_pkg::duty_of(r_work[tmcc_pkg::SET_SEC_DUTY]);
                        n_run_len   = r_work[tmcc_pkg::SET_SEC_TIME];
                        n_run_ticks = 16'd0;
                        n_running   = 1'b1;
                    end
                    tmcc_pkg::CMD_RIGHT: begin
                        n_lines     = 5'b00001;
                        n_duty      = tmcc_pkg::duty_of(r_work[tmcc_pkg::SET_MAIN_DUTY]);
                        n_run_len   = r_work[tmcc_pkg::SET_MAIN_TIME];
                        n_run_ticks = 16'd0;
                        n_running   = 1'b1;
                        n_sel       = (r_sel >= tmcc_pkg::SEL_LAST) ? tmcc_pkg::SEL_FIRST
                                                                    : r_sel + 2'd1;
                    end
                    tmcc_pkg::CMD_LEFT: begin
                        n_lines     = 5'b00010;
                        n_duty      = tmcc_pkg::duty_of(r_work[tmcc_pkg::SET_MAIN_DUTY]);
                        n_run_len   = r_work[tmcc_pkg::SET_MAIN_TIME];
                        n_run_ticks = 16'd0;
                        n_running   = 1'b1;
                        n_sel       = (r_sel <= tmcc_pkg::SEL_FIRST) ? tmcc_pkg::SEL_LAST
                                                                     : r_sel - 2'd1;
                    end
                    tmcc_pkg::CMD_STOP: begin
                        n_lines = 5'b00000;
                    end
                    default: begin
                        n_lines = r_lines;
                    end
                endcase
            end
        end else begin
            n_idle      = (r_idle < tmcc_pkg::IDLE_SAT) ? r_idle + 7'd1 : r_idle;
            n_run_ticks = r_run_ticks + 16'd1;

            if (i_item.menu_button) begin
                n_idle = 7'd0;
                if (r_mode == tmcc_pkg::MODE_LAST) begin
                    // leaving the last setting saves them all
                    n_saved = r_work;
                    n_mode  = tmcc_pkg::MODE_RUN;
                end else if (r_mode > tmcc_pkg::MODE_LAST) begin
                    n_mode = tmcc_pkg::MODE_RUN;
                end else begin
                    n_mode = r_mode + 3'd1;
                end
            end else if (i_item.adjust_button) begin
                n_idle = 7'd0;
                for (int k = 0; k < tmcc_pkg::NUM_SETTINGS; k++) begin
                    if (r_mode == 3'(k + 1)) begin
                        if (k[0] == 1'b0) begin
                            // duty settings wrap to zero past the maximum
                            step_val = (r_work[k] >= tmcc_pkg::DUTY_MAX) ? 8'd0
                                                                         : r_work[k] + 8'd1;
                            n_duty   = tmcc_pkg::duty_of(step_val);
                        end else begin
                            step_val = r_work[k] + 8'd1;
                        end
                        n_work[k] = step_val;
                    end
                end
            end

            if (n_idle == tmcc_pkg::IDLE_LIMIT && n_mode != tmcc_pkg::MODE_RUN) begin
                n_mode = tmcc_pkg::MODE_RUN;
                n_idle = 7'd0;
                n_work = r_saved;
            end

            if (r_running && n_run_ticks == {8'd0, r_run_len}) begin
                n_run_ticks = 16'd0;
                n_lines     = 5'b00000;
                n_running   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel       <= tmcc_pkg::SEL_FIRST;
            r_run_len   <= 8'd0;
            r_run_ticks <= 16'd0;
            r_running   <= 1'b0;
            r_mode      <= tmcc_pkg::MODE_RUN;
            r_idle      <= 7'd0;
            r_work      <= tmcc_pkg::SET_RESET;
            r_saved     <= tmcc_pkg::SET_RESET;
            r_lines     <= 5'b00000;
            r_duty      <= tmcc_pkg::DUTY_RESET;
        end else if (i_fire) begin
            r_sel       <= n_sel;
            r_run_len   <= n_run_len;
            r_run_ticks <= n_run_ticks;
            r_running   <= n_running;
            r_mode      <= n_mode;
            r_idle      <= n_idle;
            r_work      <= n_work;
            r_saved     <= n_saved;
            r_lines     <= n_lines;
            r_duty      <= n_duty;
        end
    end

    always_comb begin
        o_result.main_right_on     = n_lines[0];
        o_result.main_left_on      = n_lines[1];
        o_result.secondary_enables = n_lines[4:2];
        o_result.duty_word         = n_duty;
        o_result.menu_mode         = n_mode;
        o_result.accepting         = !n_running;
    end

endmodule

>>> rtl/tmcc_out_reg.sv
// tmcc_out_reg: result register that holds a beat until the consumer takes it
// depends on tmcc_pkg for the result beat type

module tmcc_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  tmcc_pkg::t_out_item i_result,
    input  logic               i_out_stall,
    output logic               o_advance,
    output logic               o_out_valid,
    output tmcc_pkg::t_out_item o_out_data
);

    logic                r_valid;
    tmcc_pkg::t_out_item r_data;

    // room for a new result when empty or when the held one leaves now
    assign o_advance = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_fire;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_data <= i_result;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

>>> rtl/timed_motor_command_controller.sv
// timed_motor_command_controller: top level of the serial and tick driven motor controller
// depends on tmcc_pkg, tmcc_in_reg, tmcc_core and tmcc_out_reg
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+------------------------
//  in      | input     | i_in_valid / o_in_stall  | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall| o_out_data (t_out_item)
//
// an accepted beat waits in the input register until the result register has room, then
// the state update and the result load happen together at one edge, and the result stays
// in the result register until the consumer takes it
// one beat per cycle is sustained while the output does not stall
// reset is synchronous and active low and clears all state but the two data registers
// a stalled output holds the result register; the input register fills and then stalls

module timed_motor_command_controller (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  tmcc_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output tmcc_pkg::t_out_item o_out_data
);

    logic                advance;
    logic                item_valid;
    logic                fire;
    tmcc_pkg::t_in_item  item;
    tmcc_pkg::t_out_item result;

    assign fire = item_valid && advance;

    tmcc_in_reg u_in_reg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_data    (i_in_data),
        .i_advance    (advance),
        .o_in_stall   (o_in_stall),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    tmcc_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_item   (item),
        .o_result (result)
    );

    tmcc_out_reg u_out_reg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (fire),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_advance   (advance),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

    // at most one secondary motor is driven
    a_sec_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $onehot0(o_out_data.secondary_enables))
        else $error("more than one secondary motor enabled");

    // main motor never driven both ways
    a_main_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_data.main_right_on && o_out_data.main_left_on))
        else $error("main motor driven right and left");

    // motors only run during a timed run
    a_idle_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.accepting) |->
            (!o_out_data.main_right_on && !o_out_data.main_left_on &&
             o_out_data.secondary_enables == 3'b000))
        else $error("motor on while accepting commands");

    // menu mode stays within the settings
    a_mode_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.menu_mode <= tmcc_pkg::MODE_LAST))
        else $error("menu mode out of range");

endmodule
